[rtl/nmi_histogram_distance_top_assert.svh]
// Assertion macros for the histogram distance block
`ifndef NMI_HISTOGRAM_DISTANCE_TOP_ASSERT_SVH
`define NMI_HISTOGRAM_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define NMID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NMID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nmid_pkg.sv]
// Shared constants, types and state codes for the histogram distance block
`default_nettype none
package nmid_pkg;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned MAX_BINS    = 64;
  localparam int unsigned SAMPLE_AW   = 12;
  localparam int unsigned BIN_W       = 6;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned PROD_W      = 33;
  localparam int unsigned SUM_W       = 34;

  localparam logic [6:0]  BIN_COUNT_RESET = 7'd32;
  localparam logic [16:0] DIST_ONE        = 17'd65536;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_B_RD,
    ST_B_WAIT,
    ST_B_MUL,
    ST_B_DIV,
    ST_C_RD,
    ST_C_WR,
    ST_SM_RD,
    ST_SM_WAIT,
    ST_SM_WA,
    ST_SM_LB,
    ST_SM_WB,
    ST_SJ_RD,
    ST_SJ_WAIT,
    ST_SJ_W,
    ST_SN_L,
    ST_SN_W,
    ST_F_PREP,
    ST_F_SUM,
    ST_F_CHK,
    ST_F_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] value;
  } clog_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } clog_rsp_t;

endpackage
`default_nettype wire

[rtl/nmi_histogram_distance_top.sv]
// Top level of the normalized mutual information distance block
`default_nettype none
`include "nmi_histogram_distance_top_assert.svh"
// Loading takes one sample pair per cycle while in_ready is high; pairs are
// written into a 4096-entry sample RAM while per-field min and max are
// tracked. Pairs beyond 4096 are dropped and reported. The pair marked last
// closes the data set and starts the evaluation, during which in_ready is
// low: a flat field goes straight from the check to the output; otherwise a
// clearing pass over the count RAMs runs, then each stored pair is binned
// (sample read, offset, scale, 6-step divide, count read and write back),
// then entropy sums are formed with the c*log2(c) unit for every marginal
// count and every non-empty joint count, then n*log2(n) is formed and the
// final 17-step divide runs unless the check settles it. The result register
// lets a new data set load while the result still waits for out_ready.
module nmi_histogram_distance_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample_a,
  input  logic signed [31:0] sample_b,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        distance,
  output logic               degenerate,
  output logic               dropped
);

  nmid_pkg::state_t state, state_next;

  logic [6:0]                          nbins;
  logic [nmid_pkg::CNT_W-1:0]          pair_count;
  logic signed [31:0]                  min_a, max_a, min_b, max_b;
  logic                                overflow_seen;
  logic [nmid_pkg::BIN_W-1:0]          nbm1;
  logic [nmid_pkg::CNT_W-1:0]          idx;
  logic [31:0]                         range_a, range_b;
  logic [31:0]                         off_a, off_b;
  logic [37:0]                         rem_a, rem_b;
  logic [nmid_pkg::BIN_W-1:0]          qa, qb;
  logic [2:0]                          div_k;
  logic [nmid_pkg::CNT_W-1:0]          cb;
  logic [nmid_pkg::SUM_W-1:0]          sa, sb, sab, nlogn;
  logic [nmid_pkg::SUM_W-1:0]          ta, tb, tab;
  logic [34:0]                         den;
  logic [36:0]                         num;
  logic [51:0]                         rem_f;
  logic [16:0]                         q;
  logic [4:0]                          fk;
  logic                                degen;

  logic                                accept;
  logic                                flat;
  logic [6:0]                          nbm1_in;
  logic [32:0]                         diff_a, diff_b, offd_a, offd_b;
  logic [37:0]                         prod_a, prod_b, sh_a, sh_b;
  logic [nmid_pkg::BIN_W-1:0]          ba, bb;
  logic [34:0]                         ta_d, tb_d, tab_d;
  logic [51:0]                         den_sh;
  logic [nmid_pkg::SUM_W-1:0]          prod_ext;

  logic                                s_we;
  logic [nmid_pkg::SAMPLE_AW-1:0]      s_waddr, s_raddr;
  logic [63:0]                         s_wdata, s_rdata;
  logic                                j_we;
  logic [nmid_pkg::SAMPLE_AW-1:0]      j_waddr, j_raddr;
  logic [nmid_pkg::CNT_W-1:0]          j_wdata, j_rdata;
  logic                                a_we, b_we;
  logic [nmid_pkg::BIN_W-1:0]          a_waddr, a_raddr, b_waddr, b_raddr;
  logic [nmid_pkg::CNT_W-1:0]          a_wdata, a_rdata, b_wdata, b_rdata;

  nmid_pkg::clog_req_t                 clog_req;
  nmid_pkg::clog_rsp_t                 clog_rsp;

  nmid_ram #(.WIDTH(64), .DEPTH(nmid_pkg::MAX_SAMPLES)) u_samples (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  nmid_ram #(.WIDTH(nmid_pkg::CNT_W), .DEPTH(nmid_pkg::MAX_BINS * nmid_pkg::MAX_BINS)) u_joint (
    .clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
    .raddr(j_raddr), .rdata(j_rdata)
  );

  nmid_ram #(.WIDTH(nmid_pkg::CNT_W), .DEPTH(nmid_pkg::MAX_BINS)) u_marg_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  nmid_ram #(.WIDTH(nmid_pkg::CNT_W), .DEPTH(nmid_pkg::MAX_BINS)) u_marg_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  nmid_clog u_clog (
    .clk(clk), .rst(rst), .req(clog_req), .rsp(clog_rsp)
  );

  assign in_ready = (state == nmid_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign flat     = (pair_count == '0) || (max_a == min_a) || (max_b == min_b);

  assign nbm1_in  = (nbins < 7'd2) ? 7'd1 :
                    (nbins > 7'(nmid_pkg::MAX_BINS)) ? 7'(nmid_pkg::MAX_BINS - 1) :
                    nbins - 7'd1;

  assign diff_a   = {max_a[31], max_a} - {min_a[31], min_a};
  assign diff_b   = {max_b[31], max_b} - {min_b[31], min_b};
  assign offd_a   = {s_rdata[63], s_rdata[63:32]} - {min_a[31], min_a};
  assign offd_b   = {s_rdata[31], s_rdata[31:0]} - {min_b[31], min_b};
  assign prod_a   = {6'b0, off_a} * {32'b0, nbm1};
  assign prod_b   = {6'b0, off_b} * {32'b0, nbm1};
  assign sh_a     = {6'b0, range_a} << div_k;
  assign sh_b     = {6'b0, range_b} << div_k;
  assign ba       = (qa > nbm1) ? nbm1 : qa;
  assign bb       = (qb > nbm1) ? nbm1 : qb;

  assign ta_d     = {1'b0, nlogn} - {1'b0, sa};
  assign tb_d     = {1'b0, nlogn} - {1'b0, sb};
  assign tab_d    = {1'b0, nlogn} - {1'b0, sab};
  assign den_sh   = {17'b0, den} << fk;
  assign prod_ext = {1'b0, clog_rsp.product};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nmid_pkg::ST_IDLE: begin
        if (accept && last) state_next = nmid_pkg::ST_CHECK;
      end
      nmid_pkg::ST_CHECK: begin
        state_next = flat ? nmid_pkg::ST_OUT : nmid_pkg::ST_CLEAR;
      end
      nmid_pkg::ST_CLEAR: begin
        if (idx[nmid_pkg::SAMPLE_AW-1:0] == '1) state_next = nmid_pkg::ST_B_RD;
      end
      nmid_pkg::ST_B_RD:   state_next = nmid_pkg::ST_B_WAIT;
      nmid_pkg::ST_B_WAIT: state_next = nmid_pkg::ST_B_MUL;
      nmid_pkg::ST_B_MUL:  state_next = nmid_pkg::ST_B_DIV;
      nmid_pkg::ST_B_DIV: begin
        if (div_k == 3'd0) state_next = nmid_pkg::ST_C_RD;
      end
      nmid_pkg::ST_C_RD:   state_next = nmid_pkg::ST_C_WR;
      nmid_pkg::ST_C_WR: begin
        state_next = (idx + 13'd1 == pair_count) ? nmid_pkg::ST_SM_RD : nmid_pkg::ST_B_RD;
      end
      nmid_pkg::ST_SM_RD:   state_next = nmid_pkg::ST_SM_WAIT;
      nmid_pkg::ST_SM_WAIT: state_next = nmid_pkg::ST_SM_WA;
      nmid_pkg::ST_SM_WA: begin
        if (clog_rsp.done) state_next = nmid_pkg::ST_SM_LB;
      end
      nmid_pkg::ST_SM_LB:   state_next = nmid_pkg::ST_SM_WB;
      nmid_pkg::ST_SM_WB: begin
        if (clog_rsp.done) begin
          state_next = (idx[nmid_pkg::BIN_W-1:0] == nbm1) ? nmid_pkg::ST_SJ_RD
                                                           : nmid_pkg::ST_SM_RD;
        end
      end
      nmid_pkg::ST_SJ_RD:   state_next = nmid_pkg::ST_SJ_WAIT;
      nmid_pkg::ST_SJ_WAIT: begin
        if (j_rdata != '0) state_next = nmid_pkg::ST_SJ_W;
        else if (idx[nmid_pkg::SAMPLE_AW-1:0] == '1) state_next = nmid_pkg::ST_SN_L;
        else state_next = nmid_pkg::ST_SJ_RD;
      end
      nmid_pkg::ST_SJ_W: begin
        if (clog_rsp.done) begin
          state_next = (idx[nmid_pkg::SAMPLE_AW-1:0] == '1) ? nmid_pkg::ST_SN_L
                                                             : nmid_pkg::ST_SJ_RD;
        end
      end
      nmid_pkg::ST_SN_L:    state_next = nmid_pkg::ST_SN_W;
      nmid_pkg::ST_SN_W: begin
        if (clog_rsp.done) state_next = nmid_pkg::ST_F_PREP;
      end
      nmid_pkg::ST_F_PREP:  state_next = nmid_pkg::ST_F_SUM;
      nmid_pkg::ST_F_SUM:   state_next = nmid_pkg::ST_F_CHK;
      nmid_pkg::ST_F_CHK: begin
        if (den == '0 || num[36] || num == '0 || num[35:0] >= {den, 1'b0}) begin
          state_next = nmid_pkg::ST_OUT;
        end else begin
          state_next = nmid_pkg::ST_F_DIV;
        end
      end
      nmid_pkg::ST_F_DIV: begin
        if (fk == 5'd0) state_next = nmid_pkg::ST_OUT;
      end
      nmid_pkg::ST_OUT: begin
        if (!out_valid || out_ready) state_next = nmid_pkg::ST_IDLE;
      end
      default: state_next = nmid_pkg::ST_IDLE;
    endcase
  end

  // memory and log-unit controls
  always_comb begin
    s_we     = 1'b0;
    s_waddr  = pair_count[nmid_pkg::SAMPLE_AW-1:0];
    s_wdata  = {sample_a, sample_b};
    s_raddr  = idx[nmid_pkg::SAMPLE_AW-1:0];
    j_we     = 1'b0;
    j_waddr  = idx[nmid_pkg::SAMPLE_AW-1:0];
    j_wdata  = '0;
    j_raddr  = idx[nmid_pkg::SAMPLE_AW-1:0];
    a_we     = 1'b0;
    a_waddr  = idx[nmid_pkg::BIN_W-1:0];
    a_wdata  = '0;
    a_raddr  = idx[nmid_pkg::BIN_W-1:0];
    b_we     = 1'b0;
    b_waddr  = idx[nmid_pkg::BIN_W-1:0];
    b_wdata  = '0;
    b_raddr  = idx[nmid_pkg::BIN_W-1:0];
    clog_req.start = 1'b0;
    clog_req.value = pair_count;
    case (state)
      nmid_pkg::ST_IDLE: begin
        s_we = accept && !pair_count[nmid_pkg::CNT_W-1];
      end
      nmid_pkg::ST_CLEAR: begin
        j_we = 1'b1;
        a_we = (idx[nmid_pkg::SAMPLE_AW-1:nmid_pkg::BIN_W] == '0);
        b_we = (idx[nmid_pkg::SAMPLE_AW-1:nmid_pkg::BIN_W] == '0);
      end
      nmid_pkg::ST_C_RD: begin
        j_raddr = {ba, bb};
        a_raddr = ba;
        b_raddr = bb;
      end
      nmid_pkg::ST_C_WR: begin
        j_we    = 1'b1;
        j_waddr = {ba, bb};
        j_wdata = j_rdata + 13'd1;
        a_we    = 1'b1;
        a_waddr = ba;
        a_wdata = a_rdata + 13'd1;
        b_we    = 1'b1;
        b_waddr = bb;
        b_wdata = b_rdata + 13'd1;
      end
      nmid_pkg::ST_SM_WAIT: begin
        clog_req.start = 1'b1;
        clog_req.value = a_rdata;
      end
      nmid_pkg::ST_SM_LB: begin
        clog_req.start = 1'b1;
        clog_req.value = cb;
      end
      nmid_pkg::ST_SJ_WAIT: begin
        clog_req.start = (j_rdata != '0);
        clog_req.value = j_rdata;
      end
      nmid_pkg::ST_SN_L: begin
        clog_req.start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nmid_pkg::ST_IDLE;
      nbins         <= nmid_pkg::BIN_COUNT_RESET;
      pair_count    <= '0;
      min_a         <= 32'sh7FFFFFFF;
      max_a         <= 32'sh80000000;
      min_b         <= 32'sh7FFFFFFF;
      max_b         <= 32'sh80000000;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) nbins <= cfg_data;
      if (state == nmid_pkg::ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        nmid_pkg::ST_IDLE: begin
          if (accept) begin
            if (!pair_count[nmid_pkg::CNT_W-1]) begin
              pair_count <= pair_count + 13'd1;
              if (sample_a < min_a) min_a <= sample_a;
              if (sample_a > max_a) max_a <= sample_a;
              if (sample_b < min_b) min_b <= sample_b;
              if (sample_b > max_b) max_b <= sample_b;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        nmid_pkg::ST_OUT: begin
          if (!out_valid || out_ready) begin
            pair_count    <= '0;
            min_a         <= 32'sh7FFFFFFF;
            max_a         <= 32'sh80000000;
            min_b         <= 32'sh7FFFFFFF;
            max_b         <= 32'sh80000000;
            overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      nmid_pkg::ST_CHECK: begin
        nbm1    <= nbm1_in[nmid_pkg::BIN_W-1:0];
        range_a <= diff_a[31:0];
        range_b <= diff_b[31:0];
        idx     <= '0;
        sa      <= '0;
        sb      <= '0;
        sab     <= '0;
        q       <= '0;
        degen   <= flat;
      end
      nmid_pkg::ST_CLEAR: begin
        idx <= (idx[nmid_pkg::SAMPLE_AW-1:0] == '1) ? '0 : idx + 13'd1;
      end
      nmid_pkg::ST_B_WAIT: begin
        off_a <= offd_a[31:0];
        off_b <= offd_b[31:0];
      end
      nmid_pkg::ST_B_MUL: begin
        rem_a <= prod_a;
        rem_b <= prod_b;
        qa    <= '0;
        qb    <= '0;
        div_k <= 3'(nmid_pkg::BIN_W - 1);
      end
      nmid_pkg::ST_B_DIV: begin
        if (rem_a >= sh_a) begin
          rem_a     <= rem_a - sh_a;
          qa[div_k] <= 1'b1;
        end
        if (rem_b >= sh_b) begin
          rem_b     <= rem_b - sh_b;
          qb[div_k] <= 1'b1;
        end
        div_k <= div_k - 3'd1;
      end
      nmid_pkg::ST_C_WR: begin
        idx <= (idx + 13'd1 == pair_count) ? '0 : idx + 13'd1;
      end
      nmid_pkg::ST_SM_WAIT: begin
        cb <= b_rdata;
      end
      nmid_pkg::ST_SM_WA: begin
        if (clog_rsp.done) sa <= sa + prod_ext;
      end
      nmid_pkg::ST_SM_WB: begin
        if (clog_rsp.done) begin
          sb  <= sb + prod_ext;
          idx <= (idx[nmid_pkg::BIN_W-1:0] == nbm1) ? '0 : idx + 13'd1;
        end
      end
      nmid_pkg::ST_SJ_WAIT: begin
        if (j_rdata == '0) idx <= idx + 13'd1;
      end
      nmid_pkg::ST_SJ_W: begin
        if (clog_rsp.done) begin
          sab <= sab + prod_ext;
          idx <= idx + 13'd1;
        end
      end
      nmid_pkg::ST_SN_W: begin
        if (clog_rsp.done) nlogn <= prod_ext;
      end
      nmid_pkg::ST_F_PREP: begin
        ta  <= ta_d[34]  ? '0 : ta_d[nmid_pkg::SUM_W-1:0];
        tb  <= tb_d[34]  ? '0 : tb_d[nmid_pkg::SUM_W-1:0];
        tab <= tab_d[34] ? '0 : tab_d[nmid_pkg::SUM_W-1:0];
      end
      nmid_pkg::ST_F_SUM: begin
        den <= {1'b0, ta} + {1'b0, tb};
        num <= {2'b0, tab, 1'b0} - {3'b0, ta} - {3'b0, tb};
      end
      nmid_pkg::ST_F_CHK: begin
        // zero entropy sum or ratio at or above two saturates here; no gain is zero
        if (den == '0) begin
          q <= nmid_pkg::DIST_ONE;
        end else if (num[36] || num == '0) begin
          q <= '0;
        end else if (num[35:0] >= {den, 1'b0}) begin
          q <= nmid_pkg::DIST_ONE;
        end else begin
          rem_f <= {num[35:0], 16'b0};
          q     <= '0;
          fk    <= 5'd16;
        end
      end
      nmid_pkg::ST_F_DIV: begin
        if (rem_f >= den_sh) begin
          rem_f <= rem_f - den_sh;
          q[fk] <= 1'b1;
        end
        fk <= fk - 5'd1;
      end
      nmid_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          distance   <= (q > nmid_pkg::DIST_ONE) ? nmid_pkg::DIST_ONE : q;
          degenerate <= degen;
          dropped    <= overflow_seen;
        end
      end
      default: ;
    endcase
  end

  `NMID_ASSERT_SAME(a_pair_cap, 1'b1, pair_count <= 13'(nmid_pkg::MAX_SAMPLES), "pair count past capacity")
  `NMID_ASSERT_SAME(a_dist_range, out_valid, distance <= nmid_pkg::DIST_ONE, "distance above one")
  `NMID_ASSERT_SAME(a_degen_zero, out_valid && degenerate, distance == '0, "flat field with nonzero distance")
  `NMID_ASSERT_NEXT(a_last_starts, accept && last, state == nmid_pkg::ST_CHECK, "last pair did not start evaluation")

endmodule
`default_nettype wire

[rtl/nmid_ram.sv]
// Generic simple dual-port RAM with registered read
`default_nettype none
module nmid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/nmid_clog.sv]
// Iterative c * log2(c) unit, log2 in Q.16 by repeated squaring
`default_nettype none
module nmid_clog (
  input  logic                clk,
  input  logic                rst,
  input  nmid_pkg::clog_req_t req,
  output nmid_pkg::clog_rsp_t rsp
);

  logic                         busy;
  logic [4:0]                   iter;
  logic [nmid_pkg::CNT_W-1:0]   c;
  logic [3:0]                   e;
  logic [30:0]                  m;
  logic [15:0]                  frac;
  logic [3:0]                   e_in;
  logic [30:0]                  m_in;
  logic [61:0]                  sq;
  logic [31:0]                  sq_hi;

  always_comb begin
    e_in = 4'd0;
    for (int i = 1; i < nmid_pkg::CNT_W; i++) begin
      if (req.value[i]) begin
        e_in = 4'(i);
      end
    end
  end

  assign m_in  = {18'b0, req.value} << (5'd30 - {1'b0, e_in});
  assign sq    = {31'b0, m} * {31'b0, m};
  assign sq_hi = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= 5'd16;
        c    <= req.value;
        e    <= e_in;
        m    <= m_in;
        frac <= '0;
      end else if (busy) begin
        if (iter != 5'd0) begin
          iter <= iter - 5'd1;
          if (sq_hi[31]) begin
            m    <= sq_hi[31:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= sq_hi[30:0];
            frac <= {frac[14:0], 1'b0};
          end
        end else begin
          rsp.product <= {20'b0, c} * {13'b0, e, frac};
          rsp.done    <= 1'b1;
          busy        <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/nmi_histogram_distance_top_tb.sv]
// Self-checking testbench for the normalized mutual information distance block
`timescale 1ns / 100ps
`default_nettype none
module nmi_histogram_distance_top_tb;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lst;
  } pair_t;

  typedef struct {
    logic [16:0] dist_q;
    logic        degen;
    logic        drop;
  } nmi_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [6:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] sample_a = '0;
  logic signed [31:0] sample_b = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [16:0]        distance;
  logic               degenerate;
  logic               dropped;

  pair_t       pending_pairs[$];
  nmi_result_t expected_results[$];
  int          errors = 0;
  int          pairs_sent = 0;
  int          results_seen = 0;
  int          cyc = 0;

  // predictor state
  logic [6:0]  bins_reg = nmid_pkg::BIN_COUNT_RESET;
  longint      store_a[nmid_pkg::MAX_SAMPLES];
  longint      store_b[nmid_pkg::MAX_SAMPLES];
  int          n_stored = 0;
  longint      lo_a, hi_a, lo_b, hi_b;
  bit          overflowed = 0;

  always #6 clk = ~clk;

  nmi_histogram_distance_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_a(sample_a),
    .sample_b(sample_b), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .distance(distance), .degenerate(degenerate),
    .dropped(dropped)
  );

  function automatic void open_dataset();
    n_stored = 0;
    lo_a = 64'sd2147483647;
    hi_a = -64'sd2147483648;
    lo_b = 64'sd2147483647;
    hi_b = -64'sd2147483648;
    overflowed = 0;
  endfunction

  function automatic longint unsigned log2_q16(longint unsigned c);
    int e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    while ((c >> (e + 1)) != 0) e++;
    m = c << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic longint unsigned clog(longint unsigned c);
    return (c == 0) ? 0 : c * log2_q16(c);
  endfunction

  function automatic int unsigned bin_index(longint v, longint lo, longint rng,
                                            longint unsigned nb);
    longint unsigned b;
    b = (longint'(v - lo) * (nb - 1)) / longint'(rng);
    return (b > nb - 1) ? int'(nb - 1) : int'(b);
  endfunction

  function automatic nmi_result_t nmi_distance();
    nmi_result_t r;
    longint unsigned nb, sa, sb, sab, nlogn, q;
    longint ra, rb, ta, tb, tab, num, den;
    int unsigned joint[nmid_pkg::MAX_BINS*nmid_pkg::MAX_BINS];
    int unsigned marg_a[nmid_pkg::MAX_BINS];
    int unsigned marg_b[nmid_pkg::MAX_BINS];
    int unsigned ba, bb;
    nb = bins_reg;
    if (nb < 2) nb = 2;
    if (nb > nmid_pkg::MAX_BINS) nb = nmid_pkg::MAX_BINS;
    ra = hi_a - lo_a;
    rb = hi_b - lo_b;
    r.drop = overflowed;
    r.degen = 0;
    r.dist_q = '0;
    if (n_stored == 0 || ra <= 0 || rb <= 0) begin
      r.degen = 1;
      return r;
    end
    foreach (joint[i]) joint[i] = 0;
    foreach (marg_a[i]) begin
      marg_a[i] = 0;
      marg_b[i] = 0;
    end
    for (int i = 0; i < n_stored; i++) begin
      ba = bin_index(store_a[i], lo_a, ra, nb);
      bb = bin_index(store_b[i], lo_b, rb, nb);
      marg_a[ba]++;
      marg_b[bb]++;
      joint[ba*nb + bb]++;
    end
    sa = 0;
    sb = 0;
    sab = 0;
    for (int i = 0; i < nb; i++) begin
      sa += clog(marg_a[i]);
      sb += clog(marg_b[i]);
    end
    for (int i = 0; i < nb*nb; i++) sab += clog(joint[i]);
    nlogn = clog(n_stored);
    ta = longint'(nlogn) - longint'(sa);
    tb = longint'(nlogn) - longint'(sb);
    tab = longint'(nlogn) - longint'(sab);
    if (ta < 0) ta = 0;
    if (tb < 0) tb = 0;
    if (tab < 0) tab = 0;
    den = ta + tb;
    if (den == 0) begin
      r.dist_q = nmid_pkg::DIST_ONE;
      return r;
    end
    num = 2*tab - ta - tb;
    if (num <= 0) return r;
    q = (longint'(num) << 16) / longint'(den);
    r.dist_q = (q > 65536) ? nmid_pkg::DIST_ONE : q[16:0];
    return r;
  endfunction

  function automatic void absorb_pair(pair_t p);
    if (n_stored < nmid_pkg::MAX_SAMPLES) begin
      store_a[n_stored] = p.a;
      store_b[n_stored] = p.b;
      n_stored++;
      if (p.a < lo_a) lo_a = p.a;
      if (p.a > hi_a) hi_a = p.a;
      if (p.b < lo_b) lo_b = p.b;
      if (p.b > hi_b) hi_b = p.b;
    end else begin
      overflowed = 1;
    end
    if (p.lst) begin
      expected_results.push_back(nmi_distance());
      open_dataset();
    end
  endfunction

  // idling is off in a recurring quiet window of the cycle counter
  function automatic bit take_gap();
    return ((cyc % 4000) > 1500) && ($urandom_range(99) < 17);
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // driver
  always @(posedge clk) begin
    bit accepted;
    pair_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        absorb_pair('{sample_a, sample_b, last});
        pairs_sent++;
      end
      if ((!in_valid || accepted) && pending_pairs.size() > 0 && !take_gap()) begin
        p = pending_pairs.pop_front();
        sample_a <= p.a;
        sample_b <= p.b;
        last <= p.lst;
        in_valid <= 1'b1;
      end else if (accepted) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    nmi_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction: distance %0d degenerate %0b dropped %0b",
                   $time, distance, degenerate, dropped);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (distance !== e.dist_q) begin
            $display("%0t: distance expected %0d actual %0d", $time, e.dist_q, distance);
            errors++;
          end
          if (degenerate !== e.degen) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degenerate);
            errors++;
          end
          if (dropped !== e.drop) begin
            $display("%0t: dropped expected %0b actual %0b", $time, e.drop, dropped);
            errors++;
          end
        end
      end
      out_ready <= !take_gap();
    end
  end

  task automatic add_pair(logic signed [31:0] a, logic signed [31:0] b, logic lst);
    pair_t p;
    p.a = a;
    p.b = b;
    p.lst = lst;
    pending_pairs.push_back(p);
  endtask

  function automatic logic signed [31:0] rand_value(int mode, logic signed [31:0] base);
    case (mode)
      0: return $urandom;
      1: return base + $signed($urandom_range(255)) - 128;
      2: return base;
      default: return $urandom_range(3) << 16;
    endcase
  endfunction

  task automatic add_random_set(int len);
    int mode_a, mode_b;
    logic signed [31:0] base, a, b;
    mode_a = $urandom_range(3);
    mode_b = $urandom_range(4);
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      a = rand_value(mode_a, base);
      b = (mode_b == 4) ? a + $signed($urandom_range(15)) : rand_value(mode_b, ~base);
      add_pair(a, b, i == len - 1);
    end
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_bins(logic [6:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    bins_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [6:0] bin_plan[$];
    open_dataset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_bins(7'd32);

    // directed: single pair, extremes, identical, flat, permuted pairing
    add_pair(32'sh12345678, -32'sd5, 1'b1);
    add_pair(32'sh80000000, 32'sh7fffffff, 1'b0);
    add_pair(32'sh7fffffff, 32'sh80000000, 1'b1);
    for (int i = 0; i < 6; i++) add_pair(i << 16, i << 16, i == 5);
    for (int i = 0; i < 4; i++) add_pair(i, 32'sd7, i == 3);
    for (int i = 0; i < 8; i++) add_pair(i, (i * 5) % 8, i == 7);
    drain();

    bin_plan = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd1, 7'd65, 7'd32};
    for (int k = 0; k < 4; k++) bin_plan.push_back($urandom_range(127));
    foreach (bin_plan[k]) begin
      write_bins(bin_plan[k]);
      for (int s = 0; s < 7; s++) add_random_set($urandom_range(14) + 1);
      drain();
    end

    $display("Sent %0d sample pairs, checked %0d results over %0d bin settings.",
             pairs_sent, results_seen, bin_plan.size() + 1);
    $display("Covered flat fields, full-scale extremes, correlated data and bin clamping.");
    if (errors == 0) begin
      $display("nmi_histogram_distance_top_tb: PASS");
    end else begin
      $display("nmi_histogram_distance_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("nmi_histogram_distance_top_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
